// ===== hdl/est_pkg.sv =====
// Shared types and constants for the EDI segment tokenizer.
package est_pkg;

  localparam int unsigned MaxSegments   = 65536;
  localparam int unsigned MaxElements   = 256;
  localparam int unsigned MaxComponents = 64;

  localparam int unsigned SegW  = 16;
  localparam int unsigned ElemW = 8;
  localparam int unsigned CompW = 6;

  // Counters stop at the smaller of (limit - 1) and the field maximum.
  localparam logic [SegW-1:0]  SegCap  = SegW'((MaxSegments - 1) < ((1 << SegW) - 1) ?
                                               (MaxSegments - 1) : ((1 << SegW) - 1));
  localparam logic [ElemW-1:0] ElemCap = ElemW'((MaxElements - 1) < ((1 << ElemW) - 1) ?
                                                (MaxElements - 1) : ((1 << ElemW) - 1));
  localparam logic [CompW-1:0] CompCap = CompW'((MaxComponents - 1) < ((1 << CompW) - 1) ?
                                                (MaxComponents - 1) : ((1 << CompW) - 1));

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic [7:0] SegmentSepReset   = 8'h27;
  localparam logic [7:0] ElementSepReset   = 8'h2B;
  localparam logic [7:0] ComponentSepReset = 8'h3A;
  localparam logic [7:0] TagSepReset       = 8'h2B;
  localparam logic [7:0] EscapeCharReset   = 8'h3F;

  typedef enum logic [2:0] {
    REG_SEGMENT_SEP   = 3'd0,
    REG_ELEMENT_SEP   = 3'd1,
    REG_COMPONENT_SEP = 3'd2,
    REG_TAG_SEP       = 3'd3,
    REG_ESCAPE_CHAR   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_DATA          = 3'd0,
    KIND_COMPONENT_END = 3'd1,
    KIND_ELEMENT_END   = 3'd2,
    KIND_SEGMENT_END   = 3'd3,
    KIND_MESSAGE_END   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_EMPTY        = 2'd1,
    STATUS_UNTERMINATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] segment_sep;
    logic [7:0] element_sep;
    logic [7:0] component_sep;
    logic [7:0] tag_sep;
    logic [7:0] escape_char;
  } cfg_t;

  typedef struct packed {
    logic             escape_pending;
    logic             in_segment;
    logic             seen_any_byte;
    logic [SegW-1:0]  segment_count;
    logic [ElemW-1:0] element_count;
    logic [CompW-1:0] component_count;
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [SegW-1:0]  segment_index;
    logic [ElemW-1:0] element_index;
    logic [CompW-1:0] component_index;
    status_t          status;
  } token_t;

endpackage

// ===== hdl/est_step.sv =====
// Per-byte classification and next-state logic of the tokenizer.
module est_step (
  input  est_pkg::cfg_t   cfg,
  input  est_pkg::state_t cur,
  input  logic [7:0]      in_byte,
  input  logic            end_mark,
  output est_pkg::state_t nxt,
  output logic            emit,
  output est_pkg::token_t tok
);

  logic                      skip;
  logic [est_pkg::ElemW-1:0] elem;
  logic [est_pkg::CompW-1:0] comp;
  logic [7:0]                elem_sep;

  always_comb begin
    nxt      = cur;
    emit     = 1'b0;
    skip     = 1'b0;
    elem     = cur.element_count;
    comp     = cur.component_count;
    elem_sep = cfg.element_sep;

    tok.kind            = est_pkg::KIND_DATA;
    tok.data_byte       = 8'd0;
    tok.segment_index   = cur.segment_count;
    tok.element_index   = cur.element_count;
    tok.component_index = cur.component_count;
    tok.status          = est_pkg::STATUS_OK;

    if (end_mark) begin
      emit = 1'b1;
      tok.kind = est_pkg::KIND_MESSAGE_END;
      if (cur.in_segment) begin
        tok.status = est_pkg::STATUS_UNTERMINATED;
      end else if (!cur.seen_any_byte) begin
        tok.status = est_pkg::STATUS_EMPTY;
      end
      nxt = '0;
    end else begin
      nxt.seen_any_byte = 1'b1;
      // Drop line breaks between segments; any other byte opens a segment.
      if (!cur.in_segment) begin
        if (in_byte == est_pkg::CharCr || in_byte == est_pkg::CharLf) begin
          skip = 1'b1;
        end else begin
          nxt.in_segment = 1'b1;
          elem = '0;
          comp = '0;
        end
      end
      nxt.element_count   = elem;
      nxt.component_count = comp;
      tok.element_index   = elem;
      tok.component_index = comp;
      if (elem == '0) begin
        elem_sep = cfg.tag_sep;
      end

      if (!skip) begin
        if (cur.escape_pending) begin
          nxt.escape_pending = 1'b0;
          emit = 1'b1;
          tok.data_byte = in_byte;
        end else if (cfg.escape_char != 8'd0 && in_byte == cfg.escape_char) begin
          nxt.escape_pending = 1'b1;
        end else if (in_byte == cfg.segment_sep) begin
          emit = 1'b1;
          tok.kind = est_pkg::KIND_SEGMENT_END;
          nxt.in_segment = 1'b0;
          nxt.segment_count = (cur.segment_count == est_pkg::SegCap) ?
                              cur.segment_count : cur.segment_count + 1'b1;
          nxt.element_count   = '0;
          nxt.component_count = '0;
        end else if (in_byte == elem_sep) begin
          emit = 1'b1;
          tok.kind = est_pkg::KIND_ELEMENT_END;
          nxt.element_count = (elem == est_pkg::ElemCap) ? elem : elem + 1'b1;
          nxt.component_count = '0;
        end else if (in_byte == cfg.component_sep) begin
          emit = 1'b1;
          tok.kind = est_pkg::KIND_COMPONENT_END;
          nxt.component_count = (comp == est_pkg::CompCap) ? comp : comp + 1'b1;
        end else begin
          emit = 1'b1;
          tok.data_byte = in_byte;
        end
      end
    end
  end

endmodule

// ===== hdl/edi_segment_tokenizer_top.sv =====
// EDI segment tokenizer: the top level with registers and output buffering.
// One message byte (or an end mark) is taken per beat and produces at most one
// registered token; a new beat can be taken every cycle while in_ready is high,
// since the whole per-byte decision is a handful of compares and saturating updates.
// A two-entry output buffer (result register plus skid register) lets the input
// keep moving while a token waits; in_ready drops only while both entries hold.
// The user writes separator registers via cfg_write/cfg_index/cfg_data only
// while the block is idle (not enforced); CR and LF between segments are dropped.
module edi_segment_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_mark,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic [15:0] segment_index,
  output logic [7:0] element_index,
  output logic [5:0] component_index,
  output logic [1:0] status,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  est_pkg::cfg_t   cfg;
  est_pkg::state_t state;
  est_pkg::state_t state_next;
  est_pkg::token_t tok_new;
  est_pkg::token_t out_tok;
  est_pkg::token_t skid_tok;
  logic            emit;
  logic            skid_valid;
  logic            accept;
  logic            push;

  est_step u_step (
    .cfg      (cfg),
    .cur      (state),
    .in_byte  (in_byte),
    .end_mark (end_mark),
    .nxt      (state_next),
    .emit     (emit),
    .tok      (tok_new)
  );

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_sep   <= est_pkg::SegmentSepReset;
      cfg.element_sep   <= est_pkg::ElementSepReset;
      cfg.component_sep <= est_pkg::ComponentSepReset;
      cfg.tag_sep       <= est_pkg::TagSepReset;
      cfg.escape_char   <= est_pkg::EscapeCharReset;
    end else if (cfg_write) begin
      unique case (est_pkg::reg_index_t'(cfg_index))
        est_pkg::REG_SEGMENT_SEP:   cfg.segment_sep   <= cfg_data;
        est_pkg::REG_ELEMENT_SEP:   cfg.element_sep   <= cfg_data;
        est_pkg::REG_COMPONENT_SEP: cfg.component_sep <= cfg_data;
        est_pkg::REG_TAG_SEP:       cfg.tag_sep       <= cfg_data;
        est_pkg::REG_ESCAPE_CHAR:   cfg.escape_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register first, skid register only while the result is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_tok    <= skid_tok;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_tok <= tok_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_tok   <= tok_new;
        out_valid <= 1'b1;
      end
    end else if (push) begin
      skid_tok   <= tok_new;
      skid_valid <= 1'b1;
    end
  end

  assign kind            = out_tok.kind;
  assign data_byte       = out_tok.data_byte;
  assign segment_index   = out_tok.segment_index;
  assign element_index   = out_tok.element_index;
  assign component_index = out_tok.component_index;
  assign status          = out_tok.status;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for edi_segment_tokenizer_top: directed table, random messages, counter saturation.
module testbench;
  import est_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int DrainLimit = 5000;
  localparam int PhaseItems = 220;
  localparam int MaxReports = 40;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    token_t     tok;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_mark = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] segment_index;
  logic [7:0]  element_index;
  logic [5:0]  component_index;
  logic [1:0]  status;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'h00;

  // Tag that travels with the beat on the input side
  logic        beat_typed = 1'b0;
  token_t      beat_token = '0;

  // Predictor copy of the registers and the message state
  cfg_t             cfg;
  logic             esc_pend;
  logic             seg_open;
  logic             got_byte;
  logic [SegW-1:0]  seg_cnt;
  logic [ElemW-1:0] elem_cnt;
  logic [CompW-1:0] comp_cnt;

  token_t pending_tokens[$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     cycle_count = 0;
  int     stall_left = 0;
  bit     no_idle = 1'b0;
  bit     hold_off = 1'b0;
  bit     random_on = 1'b0;

  stim_row_t directed_rows [0:23] = '{
    '{8'h00, 1'b1, 1'b1, '{KIND_MESSAGE_END, 8'h00, 16'd0, 8'd0, 6'd0, STATUS_EMPTY}},
    '{CharCr, 1'b0, 1'b0, '0},
    '{CharLf, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b1, 1'b1, '{KIND_MESSAGE_END, 8'h00, 16'd0, 8'd0, 6'd0, STATUS_OK}},
    '{8'h55, 1'b0, 1'b1, '{KIND_DATA, 8'h55, 16'd0, 8'd0, 6'd0, STATUS_OK}},
    '{8'h4E, 1'b0, 1'b0, '0},
    '{8'h2B, 1'b0, 1'b1, '{KIND_ELEMENT_END, 8'h00, 16'd0, 8'd0, 6'd0, STATUS_OK}},
    '{8'h00, 1'b0, 1'b1, '{KIND_DATA, 8'h00, 16'd0, 8'd1, 6'd0, STATUS_OK}},
    '{8'h3A, 1'b0, 1'b1, '{KIND_COMPONENT_END, 8'h00, 16'd0, 8'd1, 6'd0, STATUS_OK}},
    '{8'hFF, 1'b0, 1'b1, '{KIND_DATA, 8'hFF, 16'd0, 8'd1, 6'd1, STATUS_OK}},
    '{8'h3F, 1'b0, 1'b0, '0},
    '{8'h27, 1'b0, 1'b0, '0},
    '{8'h3F, 1'b0, 1'b0, '0},
    '{8'h3F, 1'b0, 1'b0, '0},
    '{8'h2B, 1'b0, 1'b0, '0},
    '{8'h27, 1'b0, 1'b0, '0},
    '{8'h27, 1'b0, 1'b0, '0},
    '{CharCr, 1'b0, 1'b0, '0},
    '{CharLf, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h3F, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{KIND_MESSAGE_END, 8'h00, 16'd2, 8'd0, 6'd0, STATUS_UNTERMINATED}},
    '{8'h3A, 1'b0, 1'b1, '{KIND_COMPONENT_END, 8'h00, 16'd0, 8'd0, 6'd0, STATUS_OK}},
    '{8'hFF, 1'b1, 1'b1, '{KIND_MESSAGE_END, 8'h00, 16'd0, 8'd0, 6'd1, STATUS_UNTERMINATED}}
  };

  // Defaults, extremes, separator clashes, CR/LF as separators
  cfg_t phase_cfgs [0:4] = '{
    '{8'h27, 8'h2B, 8'h3A, 8'h2B, 8'h3F},
    '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00},
    '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h3F},
    '{8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h5C},
    '{CharCr, CharLf, 8'h2C, 8'h3A, 8'h01}
  };

  edi_segment_tokenizer_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .end_mark        (end_mark),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .data_byte       (data_byte),
    .segment_index   (segment_index),
    .element_index   (element_index),
    .component_index (component_index),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic token_t make_token(kind_t k, logic [7:0] d, status_t s);
    token_t t;
    t.kind = k;
    t.data_byte = d;
    t.segment_index = seg_cnt;
    t.element_index = elem_cnt;
    t.component_index = comp_cnt;
    t.status = s;
    return t;
  endfunction

  // Advance the tokenizer state by one beat; return 1 when a token comes out
  function automatic bit next_token(logic [7:0] b, logic last, output token_t tok);
    logic [7:0] elem_sep_now;
    tok = '0;
    if (last) begin
      tok = make_token(KIND_MESSAGE_END, 8'h00, seg_open ? STATUS_UNTERMINATED :
                       (got_byte ? STATUS_OK : STATUS_EMPTY));
      esc_pend = 1'b0;
      seg_open = 1'b0;
      got_byte = 1'b0;
      seg_cnt = '0;
      elem_cnt = '0;
      comp_cnt = '0;
      return 1'b1;
    end
    got_byte = 1'b1;
    if (!seg_open) begin
      if (b == CharCr || b == CharLf) return 1'b0;
      seg_open = 1'b1;
      elem_cnt = '0;
      comp_cnt = '0;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      tok = make_token(KIND_DATA, b, STATUS_OK);
      return 1'b1;
    end
    if (cfg.escape_char != 8'h00 && b == cfg.escape_char) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (b == cfg.segment_sep) begin
      tok = make_token(KIND_SEGMENT_END, 8'h00, STATUS_OK);
      seg_open = 1'b0;
      if (seg_cnt < SegCap) seg_cnt = seg_cnt + 1'b1;
      elem_cnt = '0;
      comp_cnt = '0;
      return 1'b1;
    end
    elem_sep_now = (elem_cnt == '0) ? cfg.tag_sep : cfg.element_sep;
    if (b == elem_sep_now) begin
      tok = make_token(KIND_ELEMENT_END, 8'h00, STATUS_OK);
      if (elem_cnt < ElemCap) elem_cnt = elem_cnt + 1'b1;
      comp_cnt = '0;
      return 1'b1;
    end
    if (b == cfg.component_sep) begin
      tok = make_token(KIND_COMPONENT_END, 8'h00, STATUS_OK);
      if (comp_cnt < CompCap) comp_cnt = comp_cnt + 1'b1;
      return 1'b1;
    end
    tok = make_token(KIND_DATA, b, STATUS_OK);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_content_byte();
    case ($urandom_range(0, 19))
      0: return cfg.segment_sep;
      1: return cfg.element_sep;
      2: return cfg.component_sep;
      3: return cfg.tag_sep;
      4: return $urandom_range(0, 1) ? CharCr : CharLf;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Observe both handshakes at the edge: predict first, then check
  always @(posedge clk) begin : observe
    token_t tok;
    token_t want;
    bit     made;
    if (!rst && in_valid && in_ready) begin
      made = next_token(in_byte, end_mark, tok);
      if (beat_typed) pending_tokens.push_back(beat_token);
      else if (made) pending_tokens.push_back(tok);
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected token: expected none, actual kind %0d data %0h",
                   $time, kind, data_byte);
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
        check_field("segment_index", want.segment_index, segment_index);
        check_field("element_index", 16'(want.element_index), 16'(element_index));
        check_field("component_index", 16'(want.component_index), 16'(component_index));
        check_field("status", 16'(want.status), 16'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-offs so the output buffer fills and in_ready drops
  initial begin : hold_off_ctl
    wait (random_on);
    repeat (60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
    repeat (1500) @(posedge clk);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** edi_segment_tokenizer_top: FAILED **");
      $finish;
    end
  end

  // Valid stays high across back-to-back beats; drop it only for a gap
  task automatic send_beat(logic [7:0] b, logic last, logic typed, token_t tok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_mark <= last;
    beat_typed <= typed;
    beat_token <= tok;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(b, 1'b0, 1'b0, '0);
  endtask

  task automatic send_content(int n);
    repeat (n) begin
      if (cfg.escape_char != 8'h00 && $urandom_range(0, 9) == 0) begin
        send_byte(cfg.escape_char);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(pick_content_byte());
      end
    end
  endtask

  // Mostly well-formed messages; some empty, some noise, some unterminated
  task automatic send_message();
    int pick;
    int nseg;
    int nel;
    int ncomp;
    pick = $urandom_range(0, 19);
    if (pick >= 1 && pick < 3) begin
      repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick >= 3) begin
      nseg = $urandom_range(1, 5);
      for (int s = 0; s < nseg; s++) begin
        if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 1) ? CharCr : CharLf);
        send_content($urandom_range(1, 3));
        nel = $urandom_range(0, 4);
        for (int e = 0; e < nel; e++) begin
          send_byte(e == 0 ? cfg.tag_sep : cfg.element_sep);
          send_content($urandom_range(0, 3));
          ncomp = $urandom_range(0, 3);
          for (int c = 0; c < ncomp; c++) begin
            send_byte(cfg.component_sep);
            send_content($urandom_range(0, 3));
          end
        end
        if (s != nseg - 1 || $urandom_range(0, 7) != 0) send_byte(cfg.segment_sep);
      end
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_SEGMENT_SEP:   cfg.segment_sep = v;
      REG_ELEMENT_SEP:   cfg.element_sep = v;
      REG_COMPONENT_SEP: cfg.component_sep = v;
      REG_TAG_SEP:       cfg.tag_sep = v;
      REG_ESCAPE_CHAR:   cfg.escape_char = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    write_reg(REG_SEGMENT_SEP, c.segment_sep);
    write_reg(REG_ELEMENT_SEP, c.element_sep);
    write_reg(REG_COMPONENT_SEP, c.component_sep);
    write_reg(REG_TAG_SEP, c.tag_sep);
    write_reg(REG_ESCAPE_CHAR, c.escape_char);
    cfg_write <= 1'b0;
  endtask

  // Drop valid, wait for every expected token, then let the pipeline empty
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_tokens.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_tokens.size() != 0) begin
      mismatches++;
      $display("%0t: missing tokens: expected %0d more, actual 0", $time,
               pending_tokens.size());
      pending_tokens.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin : main
    cfg_t c;
    int   target;
    cfg = '{SegmentSepReset, ElementSepReset, ComponentSepReset, TagSepReset, EscapeCharReset};
    esc_pend = 1'b0;
    seg_open = 1'b0;
    got_byte = 1'b0;
    seg_cnt = '0;
    elem_cnt = '0;
    comp_cnt = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].tok);

    random_on = 1'b1;
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p < 5) c = phase_cfgs[p];
      else c = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
      set_config(c);
      no_idle = (p == 3);
      target = items_sent + PhaseItems;
      while (items_sent < target) send_message();
    end

    // Drive the element and component counters into saturation, back to back
    settle();
    set_config('{SegmentSepReset, ElementSepReset, ComponentSepReset, TagSepReset,
                 EscapeCharReset});
    no_idle = 1'b1;
    send_byte(8'h41);
    send_byte(cfg.tag_sep);
    repeat (int'(ElemCap) + 5) send_byte(cfg.element_sep);
    repeat (int'(CompCap) + 5) send_byte(cfg.component_sep);
    send_byte(8'h5A);
    send_beat(8'h00, 1'b1, 1'b0, '0);
    send_beat(8'hFF, 1'b1, 1'b0, '0);
    no_idle = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("** edi_segment_tokenizer_top: PASSED **");
    end else begin
      $display("** edi_segment_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule
